### design/piecewise_linear_profile_lookup_assert.svh
// Assertion macros for the profile lookup block.
`ifndef PIECEWISE_LINEAR_PROFILE_LOOKUP_ASSERT_SVH
`define PIECEWISE_LINEAR_PROFILE_LOOKUP_ASSERT_SVH
`ifndef ASSERT_OFF
// Implication checked every clock outside reset.
`define PLPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Implication checked in the clock after the antecedent.
`define PLPL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PLPL_ASSERT_IMP(lbl, ante, cons, msg)
`define PLPL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### design/plpl_pkg.sv
`default_nettype none
package plpl_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int MAX_POSTS_DEF   = 16;

  // input commands
  localparam logic [1:0] CMD_LOAD_POINT = 2'd0;
  localparam logic [1:0] CMD_LOAD_POST  = 2'd1;
  localparam logic [1:0] CMD_EVAL       = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SPEED      = 2'd0;
  localparam logic [1:0] REG_DELAY      = 2'd1;
  localparam logic [1:0] REG_NUM_POINTS = 2'd2;
  localparam logic [1:0] REG_NUM_POSTS  = 2'd3;

  // position memory read address selects
  localparam logic [1:0] PSEL_FIRST = 2'd0;
  localparam logic [1:0] PSEL_LAST  = 2'd1;
  localparam logic [1:0] PSEL_ONE   = 2'd2;
  localparam logic [1:0] PSEL_NEXT  = 2'd3;

  // quotient bits of the interpolation fraction (0..65536)
  localparam int FRAC_BITS = 17;

  typedef struct packed {
    logic [1:0]          command;
    logic [9:0]          slot;
    logic signed [31:0]  position;
    logic signed [31:0]  height;
    logic signed [31:0]  sim_time;
  } in_item_t;

  typedef struct packed {
    logic [3:0]          post_number;
    logic signed [31:0]  displacement;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic       start;
    logic       ld_prod;
    logic       ld_first;
    logic       ld_lastp;
    logic       ld_x;
    logic       chk;
    logic       scan_step;
    logic       h0;
    logic       h1;
    logic       div_step;
    logic       mulh;
    logic       add;
    logic       emit;
    logic [1:0] pos_sel;
    logic       h_cur;
  } ctl_cmd_t;

  typedef struct packed {
    logic outside;
    logic scan_more;
    logic div_done;
    logic last_post;
    logic out_free;
  } ctl_sts_t;

endpackage
`default_nettype wire

### design/plpl_ram.sv
`default_nettype none
module plpl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/plpl_ctrl.sv
`default_nettype none
module plpl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_command,
  output logic                    in_ready,
  input  wire plpl_pkg::ctl_sts_t sts,
  output plpl_pkg::ctl_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_FIRST = 4'd2;
  localparam logic [3:0] S_LASTP = 4'd3;
  localparam logic [3:0] S_POST  = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_H0    = 4'd7;
  localparam logic [3:0] S_H1    = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_MULH  = 4'd10;
  localparam logic [3:0] S_ADD   = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.pos_sel = plpl_pkg::PSEL_FIRST;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_command == plpl_pkg::CMD_EVAL) begin
          cmd.start = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.ld_prod = 1'b1;
        cmd.pos_sel = plpl_pkg::PSEL_FIRST;
        state_nxt   = S_FIRST;
      end
      S_FIRST: begin
        cmd.ld_first = 1'b1;
        cmd.pos_sel  = plpl_pkg::PSEL_LAST;
        state_nxt    = S_LASTP;
      end
      S_LASTP: begin
        cmd.ld_lastp = 1'b1;
        state_nxt    = S_POST;
      end
      S_POST: begin
        cmd.ld_x  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.chk     = 1'b1;
        cmd.pos_sel = plpl_pkg::PSEL_ONE;
        state_nxt   = sts.outside ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.pos_sel   = plpl_pkg::PSEL_NEXT;
        if (!sts.scan_more) begin
          state_nxt = S_H0;
        end
      end
      S_H0: begin
        cmd.h0    = 1'b1;
        cmd.h_cur = 1'b1;
        state_nxt = S_H1;
      end
      S_H1: begin
        cmd.h1    = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_MULH;
        end
      end
      S_MULH: begin
        cmd.mulh  = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last_post ? S_IDLE : S_POST;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### design/plpl_dp.sv
`default_nettype none
module plpl_dp #(
  parameter int TABLE_DEPTH = plpl_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_POSTS   = plpl_pkg::MAX_POSTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_accept,
  input  wire plpl_pkg::in_item_t in_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire plpl_pkg::ctl_cmd_t cmd,
  output plpl_pkg::ctl_sts_t      sts,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output plpl_pkg::out_item_t     out_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = (MAX_POSTS > 1) ? $clog2(MAX_POSTS) : 1;
  localparam int FB = plpl_pkg::FRAC_BITS;

  // configuration registers
  logic signed [31:0] speed_r;
  logic [30:0]        delay_r;
  logic [10:0]        npts_r;
  logic [4:0]         nposts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r  <= '0;
      delay_r  <= '0;
      npts_r   <= 11'd2;
      nposts_r <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        plpl_pkg::REG_SPEED:      speed_r  <= cfg_data;
        plpl_pkg::REG_DELAY:      delay_r  <= cfg_data[30:0];
        plpl_pkg::REG_NUM_POINTS: npts_r   <= cfg_data[10:0];
        plpl_pkg::REG_NUM_POSTS:  nposts_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // clamped last breakpoint and last post indexes
  logic [AW-1:0] nm1;
  logic [PW-1:0] npm1;

  always_comb begin
    if (32'(npts_r) > TABLE_DEPTH) begin
      nm1 = AW'(TABLE_DEPTH - 1);
    end else if (npts_r < 11'd2) begin
      nm1 = AW'(1);
    end else begin
      nm1 = AW'(32'(npts_r) - 1);
    end
    if (32'(nposts_r) > MAX_POSTS) begin
      npm1 = PW'(MAX_POSTS - 1);
    end else if (nposts_r == 5'd0) begin
      npm1 = '0;
    end else begin
      npm1 = PW'(32'(nposts_r) - 1);
    end
  end

  // profile memories
  logic           pt_we;
  logic [AW-1:0]  pt_waddr;
  logic [AW-1:0]  pos_raddr, hgt_raddr;
  logic [31:0]    pos_rdata, hgt_rdata;
  logic [AW-1:0]  i_r;

  assign pt_we    = in_accept && in_data.command == plpl_pkg::CMD_LOAD_POINT
                    && 32'(in_data.slot) < TABLE_DEPTH;
  assign pt_waddr = AW'(in_data.slot);

  always_comb begin
    case (cmd.pos_sel)
      plpl_pkg::PSEL_FIRST: pos_raddr = '0;
      plpl_pkg::PSEL_LAST:  pos_raddr = nm1;
      plpl_pkg::PSEL_ONE:   pos_raddr = AW'(1);
      default:              pos_raddr = AW'(i_r + AW'(1));
    endcase
    hgt_raddr = cmd.h_cur ? i_r : AW'(i_r - AW'(1));
  end

  plpl_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (in_data.position),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  plpl_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_hgt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (in_data.height),
    .raddr (hgt_raddr),
    .rdata (hgt_rdata)
  );

  // post locations
  logic [31:0] loc_r [MAX_POSTS];

  always_ff @(posedge clk) begin
    if (in_accept && in_data.command == plpl_pkg::CMD_LOAD_POST
        && 32'(in_data.slot) < MAX_POSTS) begin
      loc_r[PW'(in_data.slot)] <= in_data.position;
    end
  end

  // datapath registers
  logic signed [31:0] t_r;
  logic               before_r;
  logic signed [64:0] prod_r;
  logic [31:0]        first_r, lastp_r;
  logic [49:0]        x_r;
  logic [31:0]        lx_r, rx_r, lh_r, rh_r;
  logic [32:0]        rem_r;
  logic [31:0]        den_r;
  logic [FB-1:0]      q_r;
  logic [4:0]         cnt_r;
  logic signed [50:0] prod2_r;
  logic [31:0]        disp_r;
  logic [PW-1:0]      k_r;

  logic signed [32:0] dt;
  logic [49:0]        x_nxt;
  logic [49:0]        x_m_lx, rx_m_lx;
  logic signed [32:0] dh;
  logic               ge;
  logic [32:0]        rem_sub;
  logic               x_le_first, x_ge_last, pos_lt_x;

  assign dt      = {t_r[31], t_r} - {2'b00, delay_r};
  assign x_nxt   = {prod_r[64], prod_r[64:16]} + {{18{loc_r[k_r][31]}}, loc_r[k_r]};
  assign x_m_lx  = x_r - {{18{lx_r[31]}}, lx_r};
  assign rx_m_lx = {{18{rx_r[31]}}, rx_r} - {{18{lx_r[31]}}, lx_r};
  assign dh      = {rh_r[31], rh_r} - {lh_r[31], lh_r};
  assign ge      = rem_r >= {1'b0, den_r};
  assign rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  assign x_le_first = $signed(x_r) <= $signed({{18{first_r[31]}}, first_r});
  assign x_ge_last  = $signed(x_r) >= $signed({{18{lastp_r[31]}}, lastp_r});
  assign pos_lt_x   = $signed({{18{pos_rdata[31]}}, pos_rdata}) < $signed(x_r);

  always_comb begin
    sts.outside   = before_r || x_le_first || x_ge_last;
    sts.scan_more = (i_r < nm1) && pos_lt_x;
    sts.div_done  = (cnt_r == 5'(FB - 1));
    sts.last_post = (k_r == npm1);
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      t_r <= in_data.sim_time;
      k_r <= '0;
    end
    // shared time offset times speed, once per evaluate
    if (cmd.ld_prod) begin
      before_r <= $signed({t_r[31], t_r}) < $signed({2'b00, delay_r});
      prod_r   <= dt * speed_r;
    end
    if (cmd.ld_first) first_r <= pos_rdata;
    if (cmd.ld_lastp) lastp_r <= pos_rdata;
    if (cmd.ld_x)     x_r     <= x_nxt;
    // range check: zero displacement outside, else linear scan setup
    if (cmd.chk) begin
      if (sts.outside) begin
        disp_r <= '0;
      end else begin
        i_r  <= AW'(1);
        lx_r <= first_r;
      end
    end
    if (cmd.scan_step) begin
      if (sts.scan_more) begin
        lx_r <= pos_rdata;
        i_r  <= AW'(i_r + AW'(1));
      end else begin
        rx_r <= pos_rdata;
      end
    end
    if (cmd.h0) lh_r <= hgt_rdata;
    if (cmd.h1) begin
      rh_r  <= hgt_rdata;
      rem_r <= x_m_lx[32:0];
      den_r <= rx_m_lx[31:0];
      cnt_r <= '0;
      q_r   <= '0;
    end
    // restoring division, one quotient bit a cycle
    if (cmd.div_step) begin
      rem_r <= {rem_sub[31:0], 1'b0};
      q_r   <= {q_r[FB-2:0], ge};
      cnt_r <= cnt_r + 5'd1;
    end
    if (cmd.mulh) prod2_r <= $signed({1'b0, q_r}) * dh;
    if (cmd.add)  disp_r  <= lh_r + prod2_r[47:16];
    if (cmd.emit) begin
      out_data.post_number  <= 4'(k_r);
      out_data.displacement <= disp_r;
      out_data.last         <= sts.last_post;
      k_r                   <= PW'(k_r + PW'(1));
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### design/piecewise_linear_profile_lookup.sv
// Road profile lookup. Load breakpoints (command 0) and post locations
// (command 1) one item per cycle. Loads are taken only while no evaluate
// runs. An evaluate item (command 2) gives one result per post in use, in
// post order, last set on the final one. After the accept, setup states form
// the time offset times speed and load the first and last breakpoint
// positions. A post whose point falls inside the profile is then located by
// a linear scan of the breakpoints (one position memory read per cycle), and
// a bit-serial division forms the 17-bit interpolation fraction. A post
// before the start delay, or at or outside the end breakpoints, skips the
// scan and division and gives zero. Each post also waits while the output
// register still holds an earlier result. A new item is taken once the
// previous evaluate has handed its last result to the output register, even
// if that result is still waiting. Configuration writes are taken every
// cycle and must only be issued while the block is idle. Profile and post
// stores are undefined until written.
`default_nettype none
`include "piecewise_linear_profile_lookup_assert.svh"
module piecewise_linear_profile_lookup #(
  parameter int TABLE_DEPTH = plpl_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_POSTS   = plpl_pkg::MAX_POSTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire plpl_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output plpl_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);

  plpl_pkg::ctl_cmd_t cmd;
  plpl_pkg::ctl_sts_t sts;
  logic               in_accept;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;

  plpl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  plpl_dp #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_POSTS(MAX_POSTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // an evaluate keeps the input closed while it runs
  `PLPL_ASSERT_NXT(a_eval_busy, in_accept && in_data.command == plpl_pkg::CMD_EVAL, !in_ready, "input open after evaluate")
  // a result only appears after an evaluate cycle
  `PLPL_ASSERT_IMP(a_emit_busy, $rose(out_valid), !$past(in_ready), "result without evaluate")
  // emit only into a free output register
  `PLPL_ASSERT_IMP(a_emit_free, cmd.emit, !out_valid || out_ready, "output overwritten")

endmodule
`default_nettype wire
